FILE: design/entab_pkg.sv
package entab_pkg;

  localparam int COLS    = 1024;
  localparam int MAX_RUN = 63;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 10;
  localparam int JUMP_W = 11;
  localparam int ADDR_W = $clog2(COLS);
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int SUM_W  = ((COL_W > JUMP_W) ? COL_W : JUMP_W) + 1;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic MODE_TEXT = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN_RD,
    S_RUN_DEC,
    S_CHAR,
    S_TAB_RD,
    S_TAB_DEC
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [JUMP_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] char_val;
    logic              last;
  } emit_t;

  // clamp a column to 1..COLS
  function automatic logic [COL_W-1:0] sat_col(input logic [SUM_W-1:0] c);
    logic [COL_W-1:0] r;
    if (c == '0) begin
      r = COL_W'(1);
    end else if (c > SUM_W'(COLS)) begin
      r = COL_W'(COLS);
    end else begin
      r = c[COL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/entab_with_tab_stop_table.sv
// channel | direction | beat fields
// in      | input     | mode_i, ch_i, column_index_i, jump_value_i
// out     | output    | out_char_o, last_o
//
// a table load, a space or a null byte is taken in idle and leaves the sequencer idle
// other characters pass through an emit state, and a tab then reads the table for its new column
// each tab or space of a flushed run takes a table read, then a decide step
// the table has a single port, shared by loads and reads, and the output a single register
// reset clears the column to 1 and the run count; table contents stay unknown
// a stalled output holds the sequencer in its emit state
module entab_with_tab_stop_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [entab_pkg::CHAR_W-1:0] ch_i,
  input  logic [entab_pkg::IDX_W-1:0]  column_index_i,
  input  logic [entab_pkg::JUMP_W-1:0] jump_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [entab_pkg::CHAR_W-1:0] out_char_o,
  output logic                         last_o
);

  entab_pkg::ram_req_t          ram_req;
  logic [entab_pkg::JUMP_W-1:0] rdata;
  entab_pkg::emit_t             emit;
  logic                         out_free;

  logic                         out_valid_q;
  logic [entab_pkg::CHAR_W-1:0] out_char_q;
  logic                         last_q;

  assign out_free = !out_valid_q || out_ready_i;

  entab_table u_table (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  entab_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .ch_i           (ch_i),
    .column_index_i (column_index_i),
    .jump_value_i   (jump_value_i),
    .ram_req_o      (ram_req),
    .rdata_i        (rdata),
    .out_free_i     (out_free),
    .emit_o         (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_char_q <= emit.char_val;
      last_q     <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

endmodule

FILE: design/entab_table.sv
module entab_table (
  input  logic                        clk_i,
  input  entab_pkg::ram_req_t         req_i,
  output logic [entab_pkg::JUMP_W-1:0] rdata_o
);

  logic [entab_pkg::JUMP_W-1:0] mem_q [entab_pkg::COLS];
  logic [entab_pkg::JUMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/entab_ctrl.sv
module entab_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         mode_i,
  input  logic [entab_pkg::CHAR_W-1:0] ch_i,
  input  logic [entab_pkg::IDX_W-1:0]  column_index_i,
  input  logic [entab_pkg::JUMP_W-1:0] jump_value_i,
  output entab_pkg::ram_req_t          ram_req_o,
  input  logic [entab_pkg::JUMP_W-1:0] rdata_i,
  input  logic                         out_free_i,
  output entab_pkg::emit_t             emit_o
);

  entab_pkg::state_e state_q, state_d;

  logic [entab_pkg::COL_W-1:0]  col_q, col_d;
  logic [entab_pkg::RUN_W-1:0]  pend_q, pend_d;
  logic [entab_pkg::RUN_W-1:0]  k_q, k_d;
  logic [entab_pkg::COL_W-1:0]  sp_q, sp_d;
  logic [entab_pkg::CHAR_W-1:0] ch_q, ch_d;

  logic                         accept;
  logic [entab_pkg::JUMP_W-1:0] gap_len;
  logic                         run_tab;
  logic [entab_pkg::RUN_W-1:0]  k_after;
  logic [entab_pkg::COL_W-1:0]  sp_after;
  logic [entab_pkg::COL_W-1:0]  col_tab;

  assign accept = in_valid_i && in_ready_o;

  // a zero distance counts as one
  assign gap_len = (rdata_i == '0) ? entab_pkg::JUMP_W'(1) : rdata_i;
  assign run_tab = entab_pkg::JUMP_W'(k_q) >= gap_len;
  assign k_after = run_tab ? (k_q - gap_len[entab_pkg::RUN_W-1:0])
                           : (k_q - entab_pkg::RUN_W'(1));
  assign sp_after = run_tab
    ? entab_pkg::sat_col(entab_pkg::SUM_W'(sp_q) + entab_pkg::SUM_W'(gap_len))
    : entab_pkg::sat_col(entab_pkg::SUM_W'(sp_q) + entab_pkg::SUM_W'(1));
  assign col_tab =
    entab_pkg::sat_col(entab_pkg::SUM_W'(col_q) + entab_pkg::SUM_W'(gap_len));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      entab_pkg::S_IDLE: begin
        if (accept && mode_i == entab_pkg::MODE_TEXT &&
            ch_i != entab_pkg::CH_NUL && ch_i != entab_pkg::CH_SPACE) begin
          state_d = (pend_q != '0) ? entab_pkg::S_RUN_RD : entab_pkg::S_CHAR;
        end
      end
      entab_pkg::S_RUN_RD: begin
        state_d = entab_pkg::S_RUN_DEC;
      end
      entab_pkg::S_RUN_DEC: begin
        if (out_free_i) begin
          state_d = (k_after == '0) ? entab_pkg::S_CHAR : entab_pkg::S_RUN_RD;
        end
      end
      entab_pkg::S_CHAR: begin
        if (out_free_i) begin
          state_d = (ch_q == entab_pkg::CH_TAB) ? entab_pkg::S_TAB_RD
                                                : entab_pkg::S_IDLE;
        end
      end
      entab_pkg::S_TAB_RD: begin
        state_d = entab_pkg::S_TAB_DEC;
      end
      entab_pkg::S_TAB_DEC: begin
        state_d = entab_pkg::S_IDLE;
      end
      default: begin
        state_d = entab_pkg::S_IDLE;
      end
    endcase
  end

  // outputs: handshake, table port and emitted beats
  always_comb begin
    in_ready_o      = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = '0;
    ram_req_o.wdata = jump_value_i;
    emit_o.valid    = 1'b0;
    emit_o.char_val = ch_q;
    emit_o.last     = 1'b0;
    case (state_q)
      entab_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        ram_req_o.addr = entab_pkg::ADDR_W'(column_index_i);
        ram_req_o.we   = accept && mode_i == entab_pkg::MODE_LOAD &&
                         (32'(column_index_i) < entab_pkg::COLS);
      end
      entab_pkg::S_RUN_RD: begin
        ram_req_o.addr = entab_pkg::ADDR_W'(sp_q - entab_pkg::COL_W'(1));
      end
      entab_pkg::S_RUN_DEC: begin
        // keep the address so a stalled beat still sees its table entry
        ram_req_o.addr  = entab_pkg::ADDR_W'(sp_q - entab_pkg::COL_W'(1));
        emit_o.valid    = out_free_i;
        emit_o.char_val = run_tab ? entab_pkg::CH_TAB : entab_pkg::CH_SPACE;
      end
      entab_pkg::S_CHAR: begin
        emit_o.valid = out_free_i;
        emit_o.last  = 1'b1;
      end
      entab_pkg::S_TAB_RD: begin
        ram_req_o.addr = entab_pkg::ADDR_W'(col_q - entab_pkg::COL_W'(1));
      end
      entab_pkg::S_TAB_DEC: begin
        ram_req_o.addr = '0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // datapath updates
  always_comb begin
    col_d  = col_q;
    pend_d = pend_q;
    k_d    = k_q;
    sp_d   = sp_q;
    ch_d   = ch_q;
    case (state_q)
      entab_pkg::S_IDLE: begin
        if (accept && mode_i == entab_pkg::MODE_TEXT) begin
          if (ch_i == entab_pkg::CH_NUL) begin
            col_d  = entab_pkg::COL_W'(1);
            pend_d = '0;
          end else if (ch_i == entab_pkg::CH_SPACE) begin
            if (32'(pend_q) < entab_pkg::MAX_RUN) begin
              pend_d = pend_q + entab_pkg::RUN_W'(1);
            end
            col_d = entab_pkg::sat_col(entab_pkg::SUM_W'(col_q) +
                                       entab_pkg::SUM_W'(1));
          end else begin
            ch_d   = ch_i;
            k_d    = pend_q;
            pend_d = '0;
            // run start clamps to column 1
            sp_d   = (col_q > entab_pkg::COL_W'(pend_q))
                     ? (col_q - entab_pkg::COL_W'(pend_q))
                     : entab_pkg::COL_W'(1);
          end
        end
      end
      entab_pkg::S_RUN_DEC: begin
        if (out_free_i) begin
          k_d  = k_after;
          sp_d = sp_after;
        end
      end
      entab_pkg::S_CHAR: begin
        if (out_free_i) begin
          if (ch_q == entab_pkg::CH_NL) begin
            col_d = entab_pkg::COL_W'(1);
          end else if (ch_q != entab_pkg::CH_TAB) begin
            col_d = entab_pkg::sat_col(entab_pkg::SUM_W'(col_q) +
                                       entab_pkg::SUM_W'(1));
          end
        end
      end
      entab_pkg::S_TAB_DEC: begin
        col_d = col_tab;
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= entab_pkg::S_IDLE;
      col_q   <= entab_pkg::COL_W'(1);
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q  <= k_d;
    sp_q <= sp_d;
    ch_q <= ch_d;
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q >= entab_pkg::COL_W'(1) && col_q <= entab_pkg::COL_W'(entab_pkg::COLS))
    else $error("column out of range");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= entab_pkg::MAX_RUN)
    else $error("pending run above limit");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == entab_pkg::S_RUN_RD || state_q == entab_pkg::S_RUN_DEC) |-> k_q != '0)
    else $error("run step with empty count");

  a_last_only_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.last) |=> state_q != entab_pkg::S_RUN_RD &&
                                      state_q != entab_pkg::S_RUN_DEC)
    else $error("run continues after final beat");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> state_q == entab_pkg::S_IDLE && pend_d == pend_q)
    else $error("table write outside idle");
`endif

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // table entries that text can reach, written before any text
  localparam int LOADED_COLS = 128;
  // widest tab distance the random loads put into that window
  localparam int GEN_MAX_GAP = 12;

  typedef struct packed {
    logic                         mode;
    logic [entab_pkg::CHAR_W-1:0] chr;
    logic [entab_pkg::IDX_W-1:0]  idx;
    logic [entab_pkg::JUMP_W-1:0] gap;
  } in_beat_t;

  typedef struct packed {
    logic [entab_pkg::CHAR_W-1:0] chr;
    logic                         fin;
  } out_beat_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic                         mode_i         = entab_pkg::MODE_TEXT;
  logic [entab_pkg::CHAR_W-1:0] ch_i           = '0;
  logic [entab_pkg::IDX_W-1:0]  column_index_i = '0;
  logic [entab_pkg::JUMP_W-1:0] jump_value_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [entab_pkg::CHAR_W-1:0] out_char_o;
  logic                         last_o;

  in_beat_t  pending_beats[$];
  out_beat_t expected_chars[$];

  // predictor state: tab-stop distances, current column, counted blanks
  logic [entab_pkg::JUMP_W-1:0] jump_tbl [entab_pkg::COLS];
  int cur_col = 1;
  int run_len = 0;

  // upper bound on the column the queued text reaches
  int gen_col = 1;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_cnt        = 0;
  int loads_in       = 0;
  int chars_in       = 0;
  int chars_out      = 0;

  entab_with_tab_stop_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .ch_i           (ch_i),
    .column_index_i (column_index_i),
    .jump_value_i   (jump_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int clip_col(input int c);
    if (c < 1) return 1;
    if (c > entab_pkg::COLS) return entab_pkg::COLS;
    return c;
  endfunction

  function automatic int tab_gap(input int c);
    int d;
    d = int'(jump_tbl[clip_col(c) - 1]);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic void emit_char(input logic [entab_pkg::CHAR_W-1:0] c,
                                    input logic fin);
    out_beat_t b;
    b.chr = c;
    b.fin = fin;
    expected_chars.push_back(b);
  endfunction

  function automatic void entab_predict(input in_beat_t b);
    int k;
    int pos;
    int d;
    if (b.mode == entab_pkg::MODE_LOAD) begin
      jump_tbl[b.idx] = b.gap;
      return;
    end
    if (b.chr == entab_pkg::CH_NUL) begin
      cur_col = 1;
      run_len = 0;
      return;
    end
    if (b.chr == entab_pkg::CH_SPACE) begin
      if (run_len < entab_pkg::MAX_RUN) run_len++;
      cur_col = clip_col(cur_col + 1);
      return;
    end
    // flush the blank run: a tab wherever the next stop is within reach
    k = run_len;
    pos = (cur_col > k) ? cur_col - k : 1;
    while (k > 0) begin
      d = tab_gap(pos);
      if (k >= d) begin
        emit_char(entab_pkg::CH_TAB, 1'b0);
        k -= d;
        pos = clip_col(pos + d);
      end else begin
        emit_char(entab_pkg::CH_SPACE, 1'b0);
        k--;
        pos = clip_col(pos + 1);
      end
    end
    run_len = 0;
    emit_char(b.chr, 1'b1);
    if (b.chr == entab_pkg::CH_NL) begin
      cur_col = 1;
    end else if (b.chr == entab_pkg::CH_TAB) begin
      cur_col = clip_col(cur_col + tab_gap(cur_col));
    end else begin
      cur_col = clip_col(cur_col + 1);
    end
  endfunction

  // driver: next beat goes out once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    in_beat_t nb;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        nb.mode = mode_i;
        nb.chr  = ch_i;
        nb.idx  = column_index_i;
        nb.gap  = jump_value_i;
        entab_predict(nb);
        if (mode_i == entab_pkg::MODE_LOAD) loads_in++;
        else chars_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = pending_beats.pop_front();
          in_valid_i     <= 1'b1;
          mode_i         <= nb.mode;
          ch_i           <= nb.chr;
          column_index_i <= nb.idx;
          jump_value_i   <= nb.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every output beat against the oldest expected char
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    out_beat_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        chars_out++;
        if (expected_chars.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected output beat: char %h last %b", out_char_o, last_o);
        end else begin
          e = expected_chars.pop_front();
          if (out_char_o !== e.chr || last_o !== e.fin) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch at beat %0d: expected char %h last %b, got %h last %b",
                       chars_out, e.chr, e.fin, out_char_o, last_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_char(input logic [entab_pkg::CHAR_W-1:0] c);
    in_beat_t b;
    b.mode = entab_pkg::MODE_TEXT;
    b.chr  = c;
    b.idx  = entab_pkg::IDX_W'($urandom);
    b.gap  = entab_pkg::JUMP_W'($urandom);
    pending_beats.push_back(b);
    if (c == entab_pkg::CH_NL || c == entab_pkg::CH_NUL) begin
      gen_col = 1;
    end else if (c == entab_pkg::CH_TAB) begin
      gen_col += GEN_MAX_GAP;
    end else begin
      gen_col++;
    end
  endtask

  task automatic push_load(input int idx, input int gap);
    in_beat_t b;
    b.mode = entab_pkg::MODE_LOAD;
    b.chr  = entab_pkg::CHAR_W'($urandom);
    b.idx  = entab_pkg::IDX_W'(idx);
    b.gap  = entab_pkg::JUMP_W'(gap);
    pending_beats.push_back(b);
  endtask

  // lines of words, blank runs, tabs and line ends, with the odd table rewrite
  task automatic gen_text(input int n_items);
    int made;
    int roll;
    int len;
    int j;
    int gap;
    made = 0;
    while (made < n_items) begin
      // end the line while the longest run and a tab still fit the loaded window
      if (gen_col > LOADED_COLS - 84) begin
        push_char(entab_pkg::CH_NL);
        made++;
      end
      roll = $urandom_range(99);
      if (roll < 45) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) push_char(entab_pkg::CHAR_W'($urandom_range(33, 126)));
        made += len;
      end else if (roll < 70) begin
        // long runs now and then to hit the run limit
        len = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 10);
        for (j = 0; j < len; j++) push_char(entab_pkg::CH_SPACE);
        made += len;
      end else if (roll < 80) begin
        push_char(entab_pkg::CH_TAB);
        made++;
      end else if (roll < 88) begin
        push_char(entab_pkg::CH_NL);
        made++;
      end else if (roll < 90) begin
        push_char(entab_pkg::CH_NUL);
        made++;
      end else if (roll < 95) begin
        push_char(entab_pkg::CHAR_W'($urandom_range(255)));
        made++;
      end else begin
        roll = $urandom_range(9);
        if (roll == 1) begin
          // wide distance into an entry the text never reaches
          push_load($urandom_range(LOADED_COLS, entab_pkg::COLS - 1),
                    $urandom_range(1, entab_pkg::COLS));
        end else begin
          gap = (roll == 0) ? 0 : $urandom_range(1, GEN_MAX_GAP);
          push_load($urandom_range(LOADED_COLS - 1), gap);
        end
        made++;
      end
    end
  endtask

  initial begin : stim_proc
    int send_pct [4];
    int recv_pct [4];
    int p;
    int i;
    send_pct = '{0, 64, 0, 27};
    recv_pct = '{0, 0, 64, 27};
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) begin
        // every column text can reach is written first, stops every 8 columns
        for (i = 0; i < LOADED_COLS; i++) push_load(i, 8 - (i % 8));
        // zero distance at column 1, tabs, flushed and dropped runs
        push_load(0, 0);
        push_char(entab_pkg::CH_TAB);
        push_char(entab_pkg::CH_SPACE);
        push_char(entab_pkg::CH_SPACE);
        push_char(8'h78);
        push_char(entab_pkg::CH_TAB);
        push_char(entab_pkg::CH_SPACE);
        push_char(entab_pkg::CH_SPACE);
        push_char(entab_pkg::CH_NUL);
        push_char(8'h41);
        push_char(entab_pkg::CH_SPACE);
        push_char(entab_pkg::CH_NL);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(8'h7F);
        // widest distances: a tab from column 1 lands on the last column
        push_load(entab_pkg::COLS - 1, entab_pkg::COLS);
        push_load(entab_pkg::COLS - 2, 1);
        push_load(entab_pkg::COLS - 3, 2);
        push_char(entab_pkg::CH_NL);
        push_load(0, entab_pkg::COLS);
        push_char(entab_pkg::CH_TAB);
        push_char(entab_pkg::CH_SPACE);
        push_char(entab_pkg::CH_SPACE);
        push_char(8'h7A);
        push_char(entab_pkg::CH_TAB);
        push_char(entab_pkg::CH_NL);
        push_load(0, 8);
        push_load(entab_pkg::COLS - 1, 1);
      end
      gen_text(56);
      while (pending_beats.size() != 0) @(posedge clk_i);
    end
    while (in_valid_i || expected_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d text beats and %0d table loads, checked %0d output beats",
             chars_in, loads_in, chars_out);
    $display("idling phases: none, sender only, receiver only, both");
    if (err_cnt == 0 && expected_chars.size() == 0) begin
      $display("PASS entab_with_tab_stop_table");
    end else begin
      $display("%0d errors", err_cnt);
      $display("FAIL entab_with_tab_stop_table");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("FAIL entab_with_tab_stop_table");
    $finish;
  end

endmodule

FILE: files.f
design/entab_pkg.sv
design/entab_table.sv
design/entab_ctrl.sv
design/entab_with_tab_stop_table.sv
verif/testbench.sv
